FILE: design/mdc_pkg.sv
// Package with the types, codes and helper functions of the maze carver.
`default_nettype none
package mdc_pkg;

    localparam int MAX_CELL_ROWS = 32;
    localparam int MAX_CELL_COLS = 32;
    localparam int CELL_COUNT    = MAX_CELL_ROWS * MAX_CELL_COLS;
    localparam int IDX_W         = $clog2(CELL_COUNT);
    localparam int DEPTH_W       = IDX_W + 1;

    // Bits of one map word.
    localparam int MAP_VIS   = 0;
    localparam int MAP_EAST  = 1;
    localparam int MAP_SOUTH = 2;

    localparam logic [1:0] CFG_SEED = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLS = 2'd2;

    localparam logic [1:0] FN_RESTART  = 2'd0;
    localparam logic [1:0] FN_STEP     = 2'd1;
    localparam logic [1:0] FN_READ     = 2'd2;
    localparam logic [1:0] FN_READ_ALT = 2'd3;

    localparam logic [2:0] EV_CARVED  = 3'd0;
    localparam logic [2:0] EV_BLOCKED = 3'd1;
    localparam logic [2:0] EV_BACK    = 3'd2;
    localparam logic [2:0] EV_DONE    = 3'd3;
    localparam logic [2:0] EV_READ    = 3'd4;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;
    localparam logic [1:0] DIR_E = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TOP,
        ST_NB,
        ST_WALL,
        ST_PUSH,
        ST_READ
    } state_t;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_VIS,
        RK_EAST,
        RK_SOUTH
    } read_kind_t;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic [4:0] perm;
        logic [2:0] tries;
    } stack_entry_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        begin
            y = x ^ (x << 13);
            y = y ^ (y >> 17);
            y = y ^ (y << 5);
            return y;
        end
    endfunction

    // Remainder by 24: the low three bits pass through, and the rest is reduced
    // modulo 3 by folding, since every even power of two is one modulo 3.
    function automatic logic [4:0] mod24(input logic [31:0] x);
        logic [28:0] q;
        logic [16:0] s1;
        logic [9:0]  s2;
        logic [5:0]  s3;
        logic [4:0]  s4;
        logic [2:0]  s5;
        logic [2:0]  s6;
        logic [1:0]  r3;
        begin
            q  = x[31:3];
            s1 = 17'(q[28:16]) + 17'(q[15:0]);
            s2 = 10'(s1[16:8]) + 10'(s1[7:0]);
            s3 = 6'(s2[9:4]) + 6'(s2[3:0]);
            s4 = 5'(s3[5:2]) + 5'(s3[1:0]);
            s5 = 3'(s4[4:2]) + 3'(s4[1:0]);
            s6 = 3'(s5[2]) + 3'(s5[1:0]);
            r3 = (s6 >= 3'd3) ? 2'(s6 - 3'd3) : s6[1:0];
            return {r3, x[2:0]};
        end
    endfunction

    function automatic logic [IDX_W-1:0] cell_idx(input logic [7:0] r, input logic [7:0] c);
        logic [19:0] t;
        begin
            t = 20'(r) * 20'(MAX_CELL_COLS) + 20'(c);
            return t[IDX_W-1:0];
        end
    endfunction

    // Direction at position pos of lexicographic permutation p of {N,S,W,E}.
    function automatic logic [1:0] perm_dir(input logic [4:0] p, input logic [1:0] pos);
        logic [7:0] w;
        begin
            case (p)
                5'd0:    w = {2'd0, 2'd1, 2'd2, 2'd3};
                5'd1:    w = {2'd0, 2'd1, 2'd3, 2'd2};
                5'd2:    w = {2'd0, 2'd2, 2'd1, 2'd3};
                5'd3:    w = {2'd0, 2'd2, 2'd3, 2'd1};
                5'd4:    w = {2'd0, 2'd3, 2'd1, 2'd2};
                5'd5:    w = {2'd0, 2'd3, 2'd2, 2'd1};
                5'd6:    w = {2'd1, 2'd0, 2'd2, 2'd3};
                5'd7:    w = {2'd1, 2'd0, 2'd3, 2'd2};
                5'd8:    w = {2'd1, 2'd2, 2'd0, 2'd3};
                5'd9:    w = {2'd1, 2'd2, 2'd3, 2'd0};
                5'd10:   w = {2'd1, 2'd3, 2'd0, 2'd2};
                5'd11:   w = {2'd1, 2'd3, 2'd2, 2'd0};
                5'd12:   w = {2'd2, 2'd0, 2'd1, 2'd3};
                5'd13:   w = {2'd2, 2'd0, 2'd3, 2'd1};
                5'd14:   w = {2'd2, 2'd1, 2'd0, 2'd3};
                5'd15:   w = {2'd2, 2'd1, 2'd3, 2'd0};
                5'd16:   w = {2'd2, 2'd3, 2'd0, 2'd1};
                5'd17:   w = {2'd2, 2'd3, 2'd1, 2'd0};
                5'd18:   w = {2'd3, 2'd0, 2'd1, 2'd2};
                5'd19:   w = {2'd3, 2'd0, 2'd2, 2'd1};
                5'd20:   w = {2'd3, 2'd1, 2'd0, 2'd2};
                5'd21:   w = {2'd3, 2'd1, 2'd2, 2'd0};
                5'd22:   w = {2'd3, 2'd2, 2'd0, 2'd1};
                5'd23:   w = {2'd3, 2'd2, 2'd1, 2'd0};
                default: w = {2'd0, 2'd1, 2'd2, 2'd3};
            endcase
            case (pos)
                2'd0:    return w[7:6];
                2'd1:    return w[5:4];
                2'd2:    return w[3:2];
                default: return w[1:0];
            endcase
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/maze_dfs_carver.sv
// Top level of the randomized depth-first maze carver.
`default_nettype none
// A word is taken when start is high and busy is low; one result word follows,
// marked by res_valid for a single cycle, and must be taken then. The maps live
// in a 1024-entry synchronous memory and the walk stack in a second one. A read
// passes through the read state; a step passes the top entry read, neighbor
// read, wall write and push write, ending early when it backs up or is blocked;
// a step on an empty stack is answered from idle. A restart sweeps the maps
// clear one entry per cycle, then pushes the start cell; after reset the same
// sweep runs before the block goes idle. Configuration writes are taken at any time.
module maze_dfs_carver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [6:0]  grid_row,
    input  wire logic [6:0]  grid_col,
    output logic             res_valid,
    output logic [2:0]       event_res,
    output logic             path_bit,
    output logic [4:0]       cell_row,
    output logic [4:0]       cell_col,
    output logic             done_res
);
    import mdc_pkg::*;

    logic [2:0]         map_mem [CELL_COUNT];
    stack_entry_t       stk_mem [CELL_COUNT];

    state_t             state_reg, state_next;
    logic [31:0]        seed_reg;
    logic [5:0]         rows_reg, cols_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [31:0]        rng_reg, rng_next;
    logic [IDX_W-1:0]   clr_reg, clr_next;
    logic               push_pend_reg, push_pend_next;
    read_kind_t         rk_reg, rk_next;
    logic [4:0]         r_reg, r_next, c_reg, c_next, nr_reg, nr_next, nc_reg, nc_next;
    logic [1:0]         dir_reg, dir_next;

    logic               res_valid_reg, res_valid_next;
    logic [2:0]         ev_reg, ev_next;
    logic               pb_reg, pb_next;
    logic [4:0]         orow_reg, orow_next, ocol_reg, ocol_next;
    logic               done_reg, done_next;

    logic [2:0]         map_q;
    stack_entry_t       stk_q;
    logic [IDX_W-1:0]   map_raddr, map_waddr;
    logic               map_we;
    logic [2:0]         map_wdata, map_wmask;
    logic [IDX_W-1:0]   stk_raddr, stk_waddr;
    logic               stk_we;
    stack_entry_t       stk_wdata;

    logic [5:0]         n_used, m_used;
    logic [6:0]         g_rlim, g_clim;
    logic               accept;
    logic [1:0]         d;
    logic [5:0]         nr6, nc6;
    logic               dir_ok;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign n_used = (rows_reg == 6'd0) ? 6'd1 :
                    (rows_reg > 6'(MAX_CELL_ROWS)) ? 6'(MAX_CELL_ROWS) : rows_reg;
    assign m_used = (cols_reg == 6'd0) ? 6'd1 :
                    (cols_reg > 6'(MAX_CELL_COLS)) ? 6'(MAX_CELL_COLS) : cols_reg;
    assign g_rlim = {n_used, 1'b1};
    assign g_clim = {m_used, 1'b1};
    assign stk_raddr = IDX_W'(depth_reg - DEPTH_W'(1));

    // Neighbor of the top entry in its current try direction.
    always_comb
    begin
        d      = perm_dir(stk_q.perm, stk_q.tries[1:0]);
        nr6    = {1'b0, stk_q.row};
        nc6    = {1'b0, stk_q.col};
        dir_ok = 1'b1;
        case (d)
            DIR_N:
            begin
                nr6    = {1'b0, stk_q.row} - 6'd1;
                dir_ok = (stk_q.row != 5'd0);
            end
            DIR_S:   nr6 = {1'b0, stk_q.row} + 6'd1;
            DIR_W:
            begin
                nc6    = {1'b0, stk_q.col} - 6'd1;
                dir_ok = (stk_q.col != 5'd0);
            end
            default: nc6 = {1'b0, stk_q.col} + 6'd1;
        endcase
        dir_ok = dir_ok && (nr6 < n_used) && (nc6 < m_used);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd1;
            rows_reg <= 6'd16;
            cols_reg <= 6'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SEED: seed_reg <= cfg_data;
                CFG_ROWS: rows_reg <= cfg_data[5:0];
                CFG_COLS: cols_reg <= cfg_data[5:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        map_q <= map_mem[map_raddr];
        stk_q <= stk_mem[stk_raddr];
        if (map_we)
        begin
            for (int b = 0; b < 3; b++)
            begin
                if (map_wmask[b])
                begin
                    map_mem[map_waddr][b] <= map_wdata[b];
                end
            end
        end
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            depth_reg     <= '0;
            rng_reg       <= 32'd1;
            clr_reg       <= '0;
            push_pend_reg <= 1'b0;
            rk_reg        <= RK_NONE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            rng_reg       <= rng_next;
            clr_reg       <= clr_next;
            push_pend_reg <= push_pend_next;
            rk_reg        <= rk_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        c_reg    <= c_next;
        nr_reg   <= nr_next;
        nc_reg   <= nc_next;
        dir_reg  <= dir_next;
        ev_reg   <= ev_next;
        pb_reg   <= pb_next;
        orow_reg <= orow_next;
        ocol_reg <= ocol_next;
        done_reg <= done_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        depth_next     = depth_reg;
        rng_next       = rng_reg;
        clr_next       = clr_reg;
        push_pend_next = push_pend_reg;
        rk_next        = rk_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        nr_next        = nr_reg;
        nc_next        = nc_reg;
        dir_next       = dir_reg;
        res_valid_next = 1'b0;
        ev_next        = ev_reg;
        pb_next        = pb_reg;
        orow_next      = orow_reg;
        ocol_next      = ocol_reg;
        done_next      = done_reg;
        map_raddr      = '0;
        map_we         = 1'b0;
        map_waddr      = '0;
        map_wdata      = '0;
        map_wmask      = '0;
        stk_we         = 1'b0;
        stk_waddr      = stk_raddr;
        stk_wdata      = stk_q;

        case (state_reg)
            ST_IDLE:
            begin
                // Address the map for a read ahead of the accepting edge.
                rk_next = RK_NONE;
                if (grid_row >= g_rlim || grid_col >= g_clim)
                begin
                    rk_next = RK_NONE;
                end
                else if (grid_row[0] && grid_col[0])
                begin
                    rk_next   = RK_VIS;
                    map_raddr = cell_idx({2'b0, grid_row[6:1]}, {2'b0, grid_col[6:1]});
                end
                else if (grid_row[0] && grid_col != 7'd0 && grid_col < {m_used, 1'b0})
                begin
                    rk_next   = RK_EAST;
                    map_raddr = cell_idx({2'b0, grid_row[6:1]},
                                         {2'b0, grid_col[6:1] - 6'd1});
                end
                else if (grid_col[0] && grid_row != 7'd0 && grid_row < {n_used, 1'b0})
                begin
                    rk_next   = RK_SOUTH;
                    map_raddr = cell_idx({2'b0, grid_row[6:1] - 6'd1},
                                         {2'b0, grid_col[6:1]});
                end
                if (!accept)
                begin
                    rk_next = rk_reg;
                end
                else if (func == FN_RESTART)
                begin
                    depth_next     = '0;
                    rng_next       = (seed_reg != 32'd0) ? seed_reg : 32'd1;
                    clr_next       = '0;
                    push_pend_next = 1'b1;
                    nr_next        = 5'd0;
                    nc_next        = 5'd0;
                    state_next     = ST_CLEAR;
                end
                else if (func == FN_STEP)
                begin
                    if (depth_reg == '0)
                    begin
                        res_valid_next = 1'b1;
                        ev_next        = EV_DONE;
                        pb_next        = 1'b0;
                        orow_next      = 5'd0;
                        ocol_next      = 5'd0;
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TOP;
                    end
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wmask = 3'b111;
                clr_next  = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(CELL_COUNT - 1))
                begin
                    state_next     = push_pend_reg ? ST_PUSH : ST_IDLE;
                    push_pend_next = 1'b0;
                end
            end

            ST_TOP:
            begin
                r_next    = stk_q.row;
                c_next    = stk_q.col;
                orow_next = stk_q.row;
                ocol_next = stk_q.col;
                pb_next   = 1'b0;
                if (stk_q.tries >= 3'd4)
                begin
                    depth_next     = depth_reg - DEPTH_W'(1);
                    res_valid_next = 1'b1;
                    ev_next        = EV_BACK;
                    done_next      = (depth_next == '0);
                    state_next     = ST_IDLE;
                end
                else
                begin
                    stk_we          = 1'b1;
                    stk_wdata.tries = stk_q.tries + 3'd1;
                    nr_next         = nr6[4:0];
                    nc_next         = nc6[4:0];
                    dir_next        = d;
                    map_raddr       = cell_idx({3'b0, nr6[4:0]}, {3'b0, nc6[4:0]});
                    if (dir_ok)
                    begin
                        state_next = ST_NB;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        ev_next        = EV_BLOCKED;
                        done_next      = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end

            ST_NB:
            begin
                if (map_q[MAP_VIS])
                begin
                    res_valid_next = 1'b1;
                    ev_next        = EV_BLOCKED;
                    done_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALL;
                end
            end

            ST_WALL:
            begin
                // The wall bit lives in the northern or western cell of the pair.
                map_we     = 1'b1;
                map_wdata  = 3'b111;
                state_next = ST_PUSH;
                case (dir_reg)
                    DIR_N:
                    begin
                        map_waddr            = cell_idx({3'b0, nr_reg}, {3'b0, c_reg});
                        map_wmask[MAP_SOUTH] = 1'b1;
                    end
                    DIR_S:
                    begin
                        map_waddr            = cell_idx({3'b0, r_reg}, {3'b0, c_reg});
                        map_wmask[MAP_SOUTH] = 1'b1;
                    end
                    DIR_W:
                    begin
                        map_waddr           = cell_idx({3'b0, r_reg}, {3'b0, nc_reg});
                        map_wmask[MAP_EAST] = 1'b1;
                    end
                    default:
                    begin
                        map_waddr           = cell_idx({3'b0, r_reg}, {3'b0, c_reg});
                        map_wmask[MAP_EAST] = 1'b1;
                    end
                endcase
            end

            ST_PUSH:
            begin
                map_we             = 1'b1;
                map_waddr          = cell_idx({3'b0, nr_reg}, {3'b0, nc_reg});
                map_wdata          = 3'b111;
                map_wmask[MAP_VIS] = 1'b1;
                if (depth_reg < DEPTH_W'(CELL_COUNT))
                begin
                    rng_next        = xorshift32(rng_reg);
                    stk_we          = 1'b1;
                    stk_waddr       = depth_reg[IDX_W-1:0];
                    stk_wdata.row   = nr_reg;
                    stk_wdata.col   = nc_reg;
                    stk_wdata.perm  = mod24(rng_next);
                    stk_wdata.tries = 3'd0;
                    depth_next      = depth_reg + DEPTH_W'(1);
                end
                res_valid_next = 1'b1;
                ev_next        = EV_CARVED;
                pb_next        = 1'b0;
                orow_next      = nr_reg;
                ocol_next      = nc_reg;
                done_next      = (depth_next == '0);
                state_next     = ST_IDLE;
            end

            ST_READ:
            begin
                res_valid_next = 1'b1;
                ev_next        = EV_READ;
                orow_next      = 5'd0;
                ocol_next      = 5'd0;
                done_next      = (depth_reg == '0);
                case (rk_reg)
                    RK_VIS:   pb_next = map_q[MAP_VIS];
                    RK_EAST:  pb_next = map_q[MAP_EAST];
                    RK_SOUTH: pb_next = map_q[MAP_SOUTH];
                    default:  pb_next = 1'b0;
                endcase
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign event_res = ev_reg;
    assign path_bit  = pb_reg;
    assign cell_row  = orow_reg;
    assign cell_col  = ocol_reg;
    assign done_res  = done_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(CELL_COUNT))
        else $error("walk stack depth beyond capacity");

    a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == FN_STEP && depth_reg == '0 |=>
        res_valid && event_res == EV_DONE && done_res)
        else $error("step on empty stack did not report finished");

    a_read_cells: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res == EV_READ |-> cell_row == 5'd0 && cell_col == 5'd0)
        else $error("read word carries a cell position");

    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !res_valid || (func == FN_STEP && $past(depth_reg) == '0) ||
        $past(func) == FN_STEP)
        else $error("result word too early after a restart or read");
`endif

endmodule
`default_nettype wire

FILE: sim/mdc_checker.sv
// Checker for the maze carver: predicts each result word and compares it with the block.
module mdc_checker
    import mdc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [31:0] cfg_data,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  func,
    input  wire logic [6:0]  grid_row,
    input  wire logic [6:0]  grid_col,
    input  wire logic        res_valid,
    input  wire logic [2:0]  event_res,
    input  wire logic        path_bit,
    input  wire logic [4:0]  cell_row,
    input  wire logic [4:0]  cell_col,
    input  wire logic        done_res,
    output int               errors,
    output int               pending
);

    typedef struct packed {
        logic [2:0] ev;
        logic       pbit;
        logic [4:0] row;
        logic [4:0] col;
        logic       done;
    } carve_word_t;

    carve_word_t expected_words[$];

    logic [31:0] seed_reg;
    logic [5:0]  rows_reg;
    logic [5:0]  cols_reg;
    bit          visited[CELL_COUNT];
    bit          east_open[CELL_COUNT];
    bit          south_open[CELL_COUNT];
    int          walk_row[CELL_COUNT];
    int          walk_col[CELL_COUNT];
    int          walk_perm[CELL_COUNT];
    int          walk_tries[CELL_COUNT];
    int          walk_depth;
    logic [31:0] dir_rng;

    function int rows_eff();
        if (rows_reg == 0) return 1;
        return (rows_reg > MAX_CELL_ROWS) ? MAX_CELL_ROWS : int'(rows_reg);
    endfunction

    function int cols_eff();
        if (cols_reg == 0) return 1;
        return (cols_reg > MAX_CELL_COLS) ? MAX_CELL_COLS : int'(cols_reg);
    endfunction

    function int cix(int r, int c);
        return (r * MAX_CELL_COLS + c) % CELL_COUNT;
    endfunction

    // Digit i of the permutation number in the factorial base picks from what is left.
    function int order_dir(int p, int pos);
        int pool[4];
        int radix[3];
        int left;
        int k;
        int d;
        pool = '{0, 1, 2, 3};
        radix = '{6, 2, 1};
        left = 4;
        d = 0;
        p = p % 24;
        for (int i = 0; i <= pos && i < 4; i++) begin
            k = (i < 3) ? p / radix[i] : 0;
            if (i < 3) p = p % radix[i];
            if (k >= left) k = left - 1;
            d = pool[k];
            for (int j = k; j + 1 < left; j++) pool[j] = pool[j + 1];
            left--;
        end
        return d;
    endfunction

    function void mark_and_push(int r, int c);
        visited[cix(r, c)] = 1;
        if (walk_depth < CELL_COUNT) begin
            dir_rng = dir_rng ^ (dir_rng << 13);
            dir_rng = dir_rng ^ (dir_rng >> 17);
            dir_rng = dir_rng ^ (dir_rng << 5);
            walk_row[walk_depth] = r;
            walk_col[walk_depth] = c;
            walk_perm[walk_depth] = int'(dir_rng % 24);
            walk_tries[walk_depth] = 0;
            walk_depth++;
        end
    endfunction

    function bit grid_bit(int gr, int gc);
        int n;
        int m;
        bit ro;
        bit co;
        n = rows_eff();
        m = cols_eff();
        ro = gr[0];
        co = gc[0];
        if (gr >= 2 * n + 1 || gc >= 2 * m + 1) return 0;
        if (ro && co) return visited[cix(gr / 2, gc / 2)];
        if (ro && gc > 0 && gc < 2 * m) return east_open[cix(gr / 2, gc / 2 - 1)];
        if (co && gr > 0 && gr < 2 * n) return south_open[cix(gr / 2 - 1, gc / 2)];
        return 0;
    endfunction

    function carve_word_t predict_word(logic [1:0] f, int gr, int gc);
        carve_word_t w;
        int t;
        int r;
        int c;
        int d;
        int nr;
        int nc;
        w = '0;
        if (f == FN_RESTART) begin
            for (int i = 0; i < CELL_COUNT; i++) begin
                visited[i] = 0;
                east_open[i] = 0;
                south_open[i] = 0;
            end
            walk_depth = 0;
            dir_rng = (seed_reg != 0) ? seed_reg : 32'd1;
            mark_and_push(0, 0);
            w.ev = EV_CARVED;
        end else if (f == FN_STEP) begin
            if (walk_depth == 0) begin
                w.ev = EV_DONE;
            end else begin
                t = walk_depth - 1;
                r = walk_row[t];
                c = walk_col[t];
                w.row = r[4:0];
                w.col = c[4:0];
                if (walk_tries[t] >= 4) begin
                    walk_depth--;
                    w.ev = EV_BACK;
                end else begin
                    d = order_dir(walk_perm[t], walk_tries[t]);
                    nr = r + ((d == DIR_N) ? -1 : (d == DIR_S) ? 1 : 0);
                    nc = c + ((d == DIR_W) ? -1 : (d == DIR_E) ? 1 : 0);
                    walk_tries[t]++;
                    if (nr >= 0 && nc >= 0 && nr < rows_eff() && nc < cols_eff() &&
                        !visited[cix(nr, nc)]) begin
                        case (d)
                            DIR_N:   south_open[cix(nr, c)] = 1;
                            DIR_S:   south_open[cix(r, c)] = 1;
                            DIR_W:   east_open[cix(r, nc)] = 1;
                            default: east_open[cix(r, c)] = 1;
                        endcase
                        mark_and_push(nr, nc);
                        w.row = nr[4:0];
                        w.col = nc[4:0];
                        w.ev = EV_CARVED;
                    end else begin
                        w.ev = EV_BLOCKED;
                    end
                end
            end
        end else begin
            w.ev = EV_READ;
            w.pbit = grid_bit(gr, gc);
        end
        w.done = (walk_depth == 0);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        carve_word_t want;
        if (!rst_n) begin
            seed_reg = 32'd1;
            rows_reg = 6'd16;
            cols_reg = 6'd16;
            for (int i = 0; i < CELL_COUNT; i++) begin
                visited[i] = 0;
                east_open[i] = 0;
                south_open[i] = 0;
            end
            walk_depth = 0;
            dir_rng = 32'd1;
            expected_words.delete();
            errors <= 0;
            pending <= 0;
        end else begin
            if (res_valid) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word ev=%0d pb=%0d r=%0d c=%0d done=%0d",
                             $time, event_res, path_bit, cell_row, cell_col, done_res);
                    errors <= errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want != {event_res, path_bit, cell_row, cell_col, done_res}) begin
                        $display({"%0t: expected ev=%0d pb=%0d r=%0d c=%0d done=%0d,",
                                  " got ev=%0d pb=%0d r=%0d c=%0d done=%0d"},
                                 $time, want.ev, want.pbit, want.row, want.col, want.done,
                                 event_res, path_bit, cell_row, cell_col, done_res);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_SEED: seed_reg = cfg_data;
                    CFG_ROWS: rows_reg = cfg_data[5:0];
                    CFG_COLS: cols_reg = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                expected_words.push_back(predict_word(func, int'(grid_row), int'(grid_col)));
            pending <= expected_words.size();
        end
    end

endmodule

FILE: sim/tb_maze_dfs_carver.sv
// Testbench top for the maze carver: drives walks, reads and settings, and gives the verdict.
module tb_maze_dfs_carver;
    import mdc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [6:0]  grid_row;
    logic [6:0]  grid_col;
    logic        res_valid;
    logic [2:0]  event_res;
    logic        path_bit;
    logic [4:0]  cell_row;
    logic [4:0]  cell_col;
    logic        done_res;
    int          errors;
    int          pending;
    int          words_sent;
    int          cycle_count = 0;
    int          gap_pct;
    int          n_rows;
    int          n_cols;

    maze_dfs_carver dut (.*);

    mdc_checker u_check (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("tb_maze_dfs_carver NOT OK");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] f, logic [6:0] gr, logic [6:0] gc);
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        grid_row <= gr;
        grid_col <= gc;
        @(posedge clk iff !busy);
        words_sent++;
        gap_pct = (words_sent < 650) ? 14 : (words_sent < 1300) ? 66 : 0;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        @(posedge clk iff pending == 0);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int eff_size(int v);
        if (v == 0) return 1;
        return (v > 32) ? 32 : v;
    endfunction

    // Reads mostly land on the grid in use, sometimes anywhere in the field.
    task automatic random_read();
        logic [1:0] f;
        f = $urandom_range(1) ? FN_READ : FN_READ_ALT;
        if ($urandom_range(3) == 0)
            send_word(f, 7'($urandom), 7'($urandom));
        else
            send_word(f, 7'($urandom_range(2 * eff_size(n_rows) + 1)),
                      7'($urandom_range(2 * eff_size(n_cols) + 1)));
    endtask

    task automatic set_size(int r, int c);
        n_rows = r;
        n_cols = c;
        cfg_write(CFG_ROWS, 32'(r) | ($urandom & 32'hFFFF_FFC0));
        cfg_write(CFG_COLS, 32'(c) | ($urandom & 32'hFFFF_FFC0));
    endtask

    function automatic int pick_size();
        case ($urandom_range(19))
            0:       return 0;
            1:       return 32;
            2:       return $urandom_range(33, 63);
            3:       return $urandom_range(9, 31);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    initial
    begin
        int steps;
        logic [31:0] sd;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_SEED;
        cfg_data = '0;
        start = 1'b0;
        func = FN_STEP;
        grid_row = '0;
        grid_col = '0;
        words_sent = 0;
        gap_pct = 14;
        n_rows = 16;
        n_cols = 16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty stack, reads before any walk, a short walk, then a tiny maze and an oversized grid.
        send_word(FN_STEP, 7'd0, 7'd0);
        send_word(FN_READ, 7'd1, 7'd1);
        send_word(FN_READ_ALT, 7'd127, 7'd127);
        send_word(FN_RESTART, 7'd0, 7'd0);
        repeat (6) send_word(FN_STEP, 7'd0, 7'd0);
        send_word(FN_READ, 7'd1, 7'd1);
        send_word(FN_READ, 7'd0, 7'd0);
        send_word(FN_READ, 7'd33, 7'd32);
        send_word(FN_READ, 7'd1, 7'd2);
        send_word(FN_READ, 7'd2, 7'd1);
        drain();
        cfg_write(CFG_SEED, 32'd0);
        set_size(2, 2);
        send_word(FN_RESTART, 7'd0, 7'd0);
        repeat (22) send_word(FN_STEP, 7'd0, 7'd0);
        send_word(FN_READ, 7'd4, 7'd3);
        send_word(FN_READ, 7'd5, 7'd5);
        drain();
        cfg_write(CFG_SEED, 32'hFFFF_FFFF);
        set_size(63, 0);
        send_word(FN_RESTART, 7'd0, 7'd0);
        repeat (10) send_word(FN_STEP, 7'd0, 7'd0);
        send_word(FN_READ, 7'd64, 7'd2);
        send_word(FN_READ_ALT, 7'd65, 7'd1);

        while (words_sent < 1950)
        begin
            drain();
            case ($urandom_range(9))
                0:       sd = 32'd0;
                1:       sd = 32'hFFFF_FFFF;
                default: sd = $urandom;
            endcase
            cfg_write(CFG_SEED, sd);
            set_size(pick_size(), pick_size());
            send_word(FN_RESTART, 7'd0, 7'd0);
            steps = 6 * eff_size(n_rows) * eff_size(n_cols) + $urandom_range(2, 8);
            if (steps > 300) steps = $urandom_range(60, 300);
            for (int i = 0; i < steps && words_sent < 1950; i++)
            begin
                case ($urandom_range(99))
                    0:
                    begin
                        // Shrink or grow the grid in the middle of a walk.
                        drain();
                        set_size(pick_size(), pick_size());
                    end
                    1:       send_word(FN_RESTART, 7'd0, 7'd0);
                    default:
                    begin
                        if ($urandom_range(99) < 20)
                            random_read();
                        else
                            send_word(FN_STEP, 7'($urandom), 7'($urandom));
                    end
                endcase
            end
            repeat ($urandom_range(1, 4)) random_read();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_maze_dfs_carver OK");
        else
            $display("tb_maze_dfs_carver NOT OK");
        $finish;
    end

endmodule
